>>> hw/rtl/bptc_pkg.sv
// Shared types and constants for the barometric pressure and temperature compensation block.
// Used by baro_pressure_temp_compensation; depends on nothing else.
`default_nettype none

package bptc_pkg;

	localparam int unsigned NUM_CFG = 6;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned COEF_W  = 16;
	localparam int unsigned RAW_W   = 24;
	localparam int unsigned ACC_W   = 64;
	localparam int unsigned MB_W    = 25;
	localparam int unsigned DT_W    = 25;
	localparam int unsigned TEMP_W  = 20;
	localparam int unsigned PRES_W  = 32;
	localparam int unsigned TOUT_W  = 16;
	localparam int unsigned REM_W   = 4;
	localparam int unsigned CNT_W   = 5;

	// scaling shifts of the compensation formulae
	localparam int unsigned SH_C5   = 8;
	localparam int unsigned SH_TEMP = 23;
	localparam int unsigned SH_C2   = 17;
	localparam int unsigned SH_OFF  = 6;
	localparam int unsigned SH_C1   = 16;
	localparam int unsigned SH_SENS = 7;
	localparam int unsigned SH_OFF2 = 4;
	localparam int unsigned SH_SEN2 = 1;
	localparam int unsigned SH_VSEN = 3;
	localparam int unsigned SH_T2   = 31;
	localparam int unsigned SH_P1   = 21;
	localparam int unsigned SH_P2   = 15;

	localparam logic [MB_W-1:0]  MUL_OFF2 = MB_W'(61);
	localparam logic [MB_W-1:0]  MUL_VOFF = MB_W'(15);
	localparam logic [REM_W:0]   DIVISOR  = (REM_W+1)'(10);

	localparam logic signed [ACC_W-1:0]  T_REF_W = 64'sd2000;
	localparam logic signed [TEMP_W-1:0] T_REF_T = 20'sd2000;
	localparam logic signed [TEMP_W-1:0] T_LOW_T = -20'sd1500;

	typedef enum logic [2:0] {
		CFG_C1 = 3'd0,
		CFG_C2 = 3'd1,
		CFG_C3 = 3'd2,
		CFG_C4 = 3'd3,
		CFG_C5 = 3'd4,
		CFG_C6 = 3'd5
	} cfg_idx_t;

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_DT     = 16'h0002,
		S_MUL    = 16'h0004,
		S_TEMP1  = 16'h0008,
		S_OFF1   = 16'h0010,
		S_SENS1  = 16'h0020,
		S_LO     = 16'h0040,
		S_OFF2   = 16'h0080,
		S_VLO    = 16'h0100,
		S_VLO2   = 16'h0200,
		S_T2     = 16'h0400,
		S_PSHIFT = 16'h0800,
		S_PSUB   = 16'h1000,
		S_PFIN   = 16'h2000,
		S_TDIV   = 16'h4000,
		S_OUT    = 16'h8000
	} state_t;

	// arithmetic shift right that truncates toward zero
	function automatic logic signed [ACC_W-1:0] trunc_shr(input logic signed [ACC_W-1:0] x,
			input int unsigned k);
		logic signed [ACC_W-1:0] bias;
		bias = (64'sd1 <<< k) - 64'sd1;
		if (x < 0)
			return (x + bias) >>> k;
		else
			return x >>> k;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/baro_pressure_temp_compensation.sv
// Barometric compensation: one shared shift-add multiplier taking one multiplier bit per cycle,
// and a one-bit-per-cycle restoring divide by ten for the temperature.
// A failed read goes straight to the output state. Otherwise the bit-serial multiplier runs
// each product over the multiplier bits up to the top set bit. There are 4 products at or
// above 20.00 C and 7 to 9 below it, then the 20-step divide. One item at a time: the next
// is taken once the result is in the output register. Output stalls hold the result back
// from that register. Reset clears the calibration words, state and handshakes.
`default_nettype none

module baro_pressure_temp_compensation (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [bptc_pkg::ADDR_W-1:0]          paddr,
	input  wire logic [bptc_pkg::DATA_W-1:0]          pwdata,
	output logic      [bptc_pkg::DATA_W-1:0]          prdata,
	output logic                                      pready,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [bptc_pkg::RAW_W-1:0]           raw_pressure,
	input  wire logic [bptc_pkg::RAW_W-1:0]           raw_temperature,
	input  wire logic                                 read_ok,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic      [bptc_pkg::PRES_W-1:0]          pressure,
	output logic signed [bptc_pkg::TOUT_W-1:0]        temperature,
	output logic                                      valid_res
);

	logic [bptc_pkg::COEF_W-1:0] cfg_q [bptc_pkg::NUM_CFG];
	logic [2:0]                  reg_idx;

	bptc_pkg::state_t state_q, ret_q;

	logic [bptc_pkg::RAW_W-1:0]         d1_q, d2_q;
	logic                               ok_q;
	logic signed [bptc_pkg::DT_W-1:0]   dt_q;
	logic signed [bptc_pkg::TEMP_W-1:0] temp_q;
	logic signed [bptc_pkg::ACC_W-1:0]  off_q, sens_q, acc_q, ma_q;
	logic [bptc_pkg::MB_W-1:0]          mb_q;
	logic [bptc_pkg::PRES_W-1:0]        p_q;
	logic [bptc_pkg::TEMP_W-1:0]        dq_q;
	logic [bptc_pkg::REM_W-1:0]         rem_q;
	logic [bptc_pkg::CNT_W-1:0]         cnt_q;
	logic                               tneg_q;
	logic                               out_valid_q, valid_res_q;
	logic [bptc_pkg::PRES_W-1:0]        last_pressure_q;
	logic [bptc_pkg::TOUT_W-1:0]        last_temp_q;

	logic signed [bptc_pkg::DT_W-1:0]   dt_calc;
	logic signed [bptc_pkg::ACC_W-1:0]  sens_calc, p_full;
	logic [bptc_pkg::DT_W-1:0]          dt_mag;
	logic [bptc_pkg::TEMP_W-1:0]        ref_gap, low_gap, temp_mag;
	logic [bptc_pkg::REM_W:0]           trial;
	logic                               trial_ge;
	logic                               out_load;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_comb begin
		prdata = '0;
		if (reg_idx < 3'(bptc_pkg::NUM_CFG))
			prdata = bptc_pkg::DATA_W'(cfg_q[reg_idx]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(bptc_pkg::NUM_CFG); i++)
				cfg_q[i] <= '0;
		end else if (psel && penable && pwrite && reg_idx < 3'(bptc_pkg::NUM_CFG)) begin
			cfg_q[reg_idx] <= pwdata[bptc_pkg::COEF_W-1:0];
		end
	end

	assign dt_calc = $signed({1'b0, d2_q})
		- $signed({1'b0, cfg_q[bptc_pkg::CFG_C5], 8'b0});
	assign sens_calc = ($signed(bptc_pkg::ACC_W'(cfg_q[bptc_pkg::CFG_C1])) <<< bptc_pkg::SH_C1)
		+ bptc_pkg::trunc_shr(acc_q, bptc_pkg::SH_SENS);
	assign p_full   = bptc_pkg::trunc_shr(acc_q, bptc_pkg::SH_P2);
	assign dt_mag   = dt_q[bptc_pkg::DT_W-1] ? -dt_q : dt_q;
	// each gap is only used where temp_q lies below its own threshold
	assign ref_gap  = bptc_pkg::T_REF_T - temp_q;
	assign low_gap  = bptc_pkg::T_LOW_T - temp_q;
	assign temp_mag = temp_q[bptc_pkg::TEMP_W-1] ? -temp_q : temp_q;
	assign trial    = {rem_q, dq_q[bptc_pkg::TEMP_W-1]};
	assign trial_ge = trial >= bptc_pkg::DIVISOR;
	// load the output register once the previous beat has gone
	assign out_load = (state_q == bptc_pkg::S_OUT) && (!out_valid_q || !out_stall);

	assign in_stall    = (state_q != bptc_pkg::S_IDLE);
	assign out_valid   = out_valid_q;
	assign valid_res   = valid_res_q;
	assign pressure    = last_pressure_q;
	assign temperature = $signed(last_temp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= bptc_pkg::S_IDLE;
			ret_q           <= bptc_pkg::S_IDLE;
			out_valid_q     <= 1'b0;
			valid_res_q     <= 1'b0;
			last_pressure_q <= '0;
			last_temp_q     <= '0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				bptc_pkg::S_IDLE: begin
					if (in_valid) begin
						d1_q    <= raw_pressure;
						d2_q    <= raw_temperature;
						ok_q    <= read_ok;
						state_q <= bptc_pkg::S_DT;
					end
				end
				bptc_pkg::S_DT: begin
					dt_q <= dt_calc;
					if (!ok_q) begin
						state_q <= bptc_pkg::S_OUT;
					end else begin
						ma_q    <= bptc_pkg::ACC_W'(dt_calc);
						mb_q    <= bptc_pkg::MB_W'(cfg_q[bptc_pkg::CFG_C6]);
						acc_q   <= '0;
						ret_q   <= bptc_pkg::S_TEMP1;
						state_q <= bptc_pkg::S_MUL;
					end
				end
				bptc_pkg::S_MUL: begin
					// add one partial product per multiplier bit
					if (mb_q == '0) begin
						state_q <= ret_q;
					end else begin
						if (mb_q[0])
							acc_q <= acc_q + ma_q;
						ma_q <= ma_q <<< 1;
						mb_q <= mb_q >> 1;
					end
				end
				bptc_pkg::S_TEMP1: begin
					temp_q  <= bptc_pkg::TEMP_W'(bptc_pkg::trunc_shr(acc_q, bptc_pkg::SH_TEMP)
						+ bptc_pkg::T_REF_W);
					ma_q    <= bptc_pkg::ACC_W'(dt_q);
					mb_q    <= bptc_pkg::MB_W'(cfg_q[bptc_pkg::CFG_C4]);
					acc_q   <= '0;
					ret_q   <= bptc_pkg::S_OFF1;
					state_q <= bptc_pkg::S_MUL;
				end
				bptc_pkg::S_OFF1: begin
					off_q   <= ($signed(bptc_pkg::ACC_W'(cfg_q[bptc_pkg::CFG_C2]))
						<<< bptc_pkg::SH_C2) + bptc_pkg::trunc_shr(acc_q, bptc_pkg::SH_OFF);
					ma_q    <= bptc_pkg::ACC_W'(dt_q);
					mb_q    <= bptc_pkg::MB_W'(cfg_q[bptc_pkg::CFG_C3]);
					acc_q   <= '0;
					ret_q   <= bptc_pkg::S_SENS1;
					state_q <= bptc_pkg::S_MUL;
				end
				bptc_pkg::S_SENS1: begin
					sens_q  <= sens_calc;
					acc_q   <= '0;
					state_q <= bptc_pkg::S_MUL;
					if (temp_q < bptc_pkg::T_REF_T) begin
						ma_q  <= $signed(bptc_pkg::ACC_W'(ref_gap));
						mb_q  <= bptc_pkg::MB_W'(ref_gap);
						ret_q <= bptc_pkg::S_LO;
					end else begin
						ma_q  <= sens_calc;
						mb_q  <= bptc_pkg::MB_W'(d1_q);
						ret_q <= bptc_pkg::S_PSHIFT;
					end
				end
				bptc_pkg::S_LO: begin
					sens_q  <= sens_q - (acc_q <<< bptc_pkg::SH_SEN2);
					ma_q    <= acc_q;
					mb_q    <= bptc_pkg::MUL_OFF2;
					acc_q   <= '0;
					ret_q   <= bptc_pkg::S_OFF2;
					state_q <= bptc_pkg::S_MUL;
				end
				bptc_pkg::S_OFF2: begin
					off_q   <= off_q - (acc_q >>> bptc_pkg::SH_OFF2);
					acc_q   <= '0;
					state_q <= bptc_pkg::S_MUL;
					// extra correction below -15.00 C, before TEMP takes T2
					if (temp_q < bptc_pkg::T_LOW_T) begin
						ma_q  <= $signed(bptc_pkg::ACC_W'(low_gap));
						mb_q  <= bptc_pkg::MB_W'(low_gap);
						ret_q <= bptc_pkg::S_VLO;
					end else begin
						ma_q  <= $signed(bptc_pkg::ACC_W'(dt_mag));
						mb_q  <= dt_mag;
						ret_q <= bptc_pkg::S_T2;
					end
				end
				bptc_pkg::S_VLO: begin
					sens_q  <= sens_q - (acc_q <<< bptc_pkg::SH_VSEN);
					ma_q    <= acc_q;
					mb_q    <= bptc_pkg::MUL_VOFF;
					acc_q   <= '0;
					ret_q   <= bptc_pkg::S_VLO2;
					state_q <= bptc_pkg::S_MUL;
				end
				bptc_pkg::S_VLO2: begin
					off_q   <= off_q - acc_q;
					ma_q    <= $signed(bptc_pkg::ACC_W'(dt_mag));
					mb_q    <= dt_mag;
					acc_q   <= '0;
					ret_q   <= bptc_pkg::S_T2;
					state_q <= bptc_pkg::S_MUL;
				end
				bptc_pkg::S_T2: begin
					temp_q  <= temp_q - bptc_pkg::TEMP_W'(acc_q >>> bptc_pkg::SH_T2);
					ma_q    <= sens_q;
					mb_q    <= bptc_pkg::MB_W'(d1_q);
					acc_q   <= '0;
					ret_q   <= bptc_pkg::S_PSHIFT;
					state_q <= bptc_pkg::S_MUL;
				end
				bptc_pkg::S_PSHIFT: begin
					acc_q   <= bptc_pkg::trunc_shr(acc_q, bptc_pkg::SH_P1);
					state_q <= bptc_pkg::S_PSUB;
				end
				bptc_pkg::S_PSUB: begin
					acc_q   <= acc_q - off_q;
					state_q <= bptc_pkg::S_PFIN;
				end
				bptc_pkg::S_PFIN: begin
					p_q     <= p_full[bptc_pkg::PRES_W-1:0];
					tneg_q  <= temp_q[bptc_pkg::TEMP_W-1];
					dq_q    <= temp_mag;
					rem_q   <= '0;
					cnt_q   <= bptc_pkg::CNT_W'(bptc_pkg::TEMP_W);
					state_q <= bptc_pkg::S_TDIV;
				end
				bptc_pkg::S_TDIV: begin
					// shift the dividend out at the top, quotient bits in at the bottom
					rem_q <= trial_ge ? bptc_pkg::REM_W'(trial - bptc_pkg::DIVISOR)
						: trial[bptc_pkg::REM_W-1:0];
					dq_q  <= {dq_q[bptc_pkg::TEMP_W-2:0], trial_ge};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == bptc_pkg::CNT_W'(1))
						state_q <= bptc_pkg::S_OUT;
				end
				bptc_pkg::S_OUT: begin
					if (out_load) begin
						valid_res_q <= ok_q;
						if (ok_q) begin
							last_pressure_q <= p_q;
							last_temp_q     <= tneg_q ? -dq_q[bptc_pkg::TOUT_W-1:0]
								: dq_q[bptc_pkg::TOUT_W-1:0];
						end
						state_q <= bptc_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= bptc_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
